### hdl/byte_stuffed_frame_builder_macros.svh
// Assertion helpers for the frame builder
`ifndef BYTE_STUFFED_FRAME_BUILDER_MACROS_SVH
`define BYTE_STUFFED_FRAME_BUILDER_MACROS_SVH

// checked out of reset only
`define BSFB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked during reset as well
`define BSFB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hdl/bsfb_pkg.sv
package bsfb_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned CfgIdxW    = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FLAG       = 3'd0,
    CFG_ESCAPE     = 3'd1,
    CFG_FLAG_SUB   = 3'd2,
    CFG_ESCAPE_SUB = 3'd3,
    CFG_ADDRESS    = 3'd4,
    CFG_CTRL_ZERO  = 3'd5,
    CFG_CTRL_ONE   = 3'd6
  } cfg_idx_e;

  localparam logic [7:0] FlagReset      = 8'h7E;
  localparam logic [7:0] EscapeReset    = 8'h7D;
  localparam logic [7:0] FlagSubReset   = 8'h5E;
  localparam logic [7:0] EscapeSubReset = 8'h5D;
  localparam logic [7:0] AddressReset   = 8'h03;
  localparam logic [7:0] CtrlZeroReset  = 8'h00;
  localparam logic [7:0] CtrlOneReset   = 8'h40;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       send_number;
    logic       empty_frame;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    logic [7:0] flag;
    logic [7:0] escape;
    logic [7:0] flag_sub;
    logic [7:0] escape_sub;
    logic [7:0] address;
    logic [7:0] ctrl_zero;
    logic [7:0] ctrl_one;
  } cfg_t;

  // one classified item, as handed from front to back
  typedef struct packed {
    logic       header;
    logic       seq_one;
    logic       has_data;
    logic [7:0] data;
    logic       trailer;
    logic [7:0] bcc;
  } cmd_t;

endpackage

### hdl/bsfb_front.sv
module bsfb_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  bsfb_pkg::in_item_t item_i,
  output bsfb_pkg::cmd_t     cmd_o
);

  logic       in_frame_q, in_frame_d;
  logic [7:0] check_q, check_d;
  logic [7:0] folded;

  always_comb begin
    in_frame_d = in_frame_q;
    check_d    = check_q;
    folded     = (in_frame_q ? check_q : 8'h00) ^ item_i.data_byte;

    cmd_o.header   = !in_frame_q;
    cmd_o.seq_one  = item_i.send_number;
    cmd_o.data     = item_i.data_byte;
    cmd_o.has_data = 1'b1;
    cmd_o.trailer  = item_i.last_byte;
    cmd_o.bcc      = folded;

    if (!in_frame_q && item_i.empty_frame) begin
      cmd_o.has_data = 1'b0;
      cmd_o.trailer  = 1'b1;
      cmd_o.bcc      = 8'h00;
    end

    if (accept_i) begin
      if (!in_frame_q && item_i.empty_frame) begin
        in_frame_d = 1'b0;
        check_d    = 8'h00;
      end else if (item_i.last_byte) begin
        in_frame_d = 1'b0;
        check_d    = 8'h00;
      end else begin
        in_frame_d = 1'b1;
        check_d    = folded;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      check_q    <= 8'h00;
    end else begin
      in_frame_q <= in_frame_d;
      check_q    <= check_d;
    end
  end

endmodule

### hdl/bsfb_queue.sv
module bsfb_queue #(
  parameter int unsigned Depth = bsfb_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bsfb_pkg::cmd_t wdata_i,
  input  logic           pop_i,
  output bsfb_pkg::cmd_t rdata_o,
  output logic           not_empty_o,
  output logic           full_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  bsfb_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign rdata_o     = mem_q[rd_ptr_q];
  assign not_empty_o = (cnt_q != '0);
  assign full_o      = (cnt_q == FullCnt);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### hdl/bsfb_back.sv
module bsfb_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bsfb_pkg::cfg_t      cfg_i,
  input  bsfb_pkg::cmd_t      cmd_i,
  input  logic                cmd_valid_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bsfb_pkg::out_item_t out_o
);

  typedef enum logic [3:0] {
    ST_START,
    ST_FLAG,
    ST_ADDR,
    ST_CTRL,
    ST_BCC1,
    ST_DATA,
    ST_DATA_SUB,
    ST_BCC,
    ST_BCC_SUB,
    ST_CLOSE
  } step_e;

  step_e               state_q, step, next;
  logic                out_valid_q;
  bsfb_pkg::out_item_t out_q;

  logic       advance, done, closing;
  logic [7:0] byte_val, ctrl;
  logic       data_flag, data_stuff, bcc_flag, bcc_stuff;
  logic [7:0] data_sub, bcc_sub;

  always_comb begin
    advance    = cmd_valid_i && (!out_valid_q || !out_stall_i);
    ctrl       = cmd_i.seq_one ? cfg_i.ctrl_one : cfg_i.ctrl_zero;
    data_flag  = (cmd_i.data == cfg_i.flag);
    data_stuff = data_flag || (cmd_i.data == cfg_i.escape);
    data_sub   = data_flag ? cfg_i.flag_sub : cfg_i.escape_sub;
    bcc_flag   = (cmd_i.bcc == cfg_i.flag);
    bcc_stuff  = bcc_flag || (cmd_i.bcc == cfg_i.escape);
    bcc_sub    = bcc_flag ? cfg_i.flag_sub : cfg_i.escape_sub;

    if (state_q == ST_START) begin
      step = cmd_i.header ? ST_FLAG : ST_DATA;
    end else begin
      step = state_q;
    end

    byte_val = cfg_i.flag;
    next     = ST_START;
    done     = 1'b0;
    closing  = 1'b0;

    case (step)
      ST_FLAG: begin
        byte_val = cfg_i.flag;
        next     = ST_ADDR;
      end
      ST_ADDR: begin
        byte_val = cfg_i.address;
        next     = ST_CTRL;
      end
      ST_CTRL: begin
        byte_val = ctrl;
        next     = ST_BCC1;
      end
      ST_BCC1: begin
        byte_val = cfg_i.address ^ ctrl;
        next     = cmd_i.has_data ? ST_DATA : ST_BCC;
      end
      ST_DATA: begin
        if (data_stuff) begin
          byte_val = cfg_i.escape;
          next     = ST_DATA_SUB;
        end else begin
          byte_val = cmd_i.data;
          next     = cmd_i.trailer ? ST_BCC : ST_START;
          done     = !cmd_i.trailer;
        end
      end
      ST_DATA_SUB: begin
        byte_val = data_sub;
        next     = cmd_i.trailer ? ST_BCC : ST_START;
        done     = !cmd_i.trailer;
      end
      ST_BCC: begin
        if (bcc_stuff) begin
          byte_val = cfg_i.escape;
          next     = ST_BCC_SUB;
        end else begin
          byte_val = cmd_i.bcc;
          next     = ST_CLOSE;
        end
      end
      ST_BCC_SUB: begin
        byte_val = bcc_sub;
        next     = ST_CLOSE;
      end
      ST_CLOSE: begin
        byte_val = cfg_i.flag;
        closing  = 1'b1;
        done     = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase

    pop_o = advance && done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_START;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      state_q         <= next;
      out_valid_q     <= 1'b1;
      out_q.out_byte  <= byte_val;
      out_q.run_last  <= done;
      out_q.frame_end <= closing;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

### hdl/byte_stuffed_frame_builder.sv
// Byte-stuffing frame builder.
// Input channel (in_valid_i / in_stall_o / in_i): one payload byte per item.
// The first item of a frame also produces flag, address, control, BCC1; an
// item with last_byte set closes the frame with stuffed BCC2 and the flag.
// empty_frame on the first item produces a complete frame with no payload.
// Output channel (out_valid_o / out_stall_i / out_o): one byte per item;
// run_last marks the final byte belonging to an input item, frame_end marks
// the closing flag.
// An accepted item is written into the command queue; the back-end builds its
// output bytes from the queue head and registers each one onto out_o.
// Throughput: one output byte per cycle from the back-end sequencer while
// out_stall_i is low, so an input item yields 1 byte (plain byte), 2 (stuffed),
// up to 9 (header, stuffed byte, stuffed BCC2, flag). A two-entry command queue lets inputs
// arrive while earlier items are still being emitted.
// When out_stall_i is held the output item holds, the queue fills and
// in_stall_o rises. Reset empties the queue, clears frame state and loads
// the default flag/escape/address/control values. Configuration writes
// (cfg_valid_i / cfg_ready_o) are always taken; use them only while idle.
`include "byte_stuffed_frame_builder_macros.svh"

module byte_stuffed_frame_builder #(
  parameter int unsigned QueueDepth = bsfb_pkg::QueueDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  bsfb_pkg::in_item_t           in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output bsfb_pkg::out_item_t          out_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bsfb_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                   cfg_data_i
);

  bsfb_pkg::cfg_t cfg_q;
  bsfb_pkg::cmd_t front_cmd, head_cmd;
  logic           accept, queue_full, head_valid, pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flag       <= bsfb_pkg::FlagReset;
      cfg_q.escape     <= bsfb_pkg::EscapeReset;
      cfg_q.flag_sub   <= bsfb_pkg::FlagSubReset;
      cfg_q.escape_sub <= bsfb_pkg::EscapeSubReset;
      cfg_q.address    <= bsfb_pkg::AddressReset;
      cfg_q.ctrl_zero  <= bsfb_pkg::CtrlZeroReset;
      cfg_q.ctrl_one   <= bsfb_pkg::CtrlOneReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bsfb_pkg::CFG_FLAG:       cfg_q.flag       <= cfg_data_i;
        bsfb_pkg::CFG_ESCAPE:     cfg_q.escape     <= cfg_data_i;
        bsfb_pkg::CFG_FLAG_SUB:   cfg_q.flag_sub   <= cfg_data_i;
        bsfb_pkg::CFG_ESCAPE_SUB: cfg_q.escape_sub <= cfg_data_i;
        bsfb_pkg::CFG_ADDRESS:    cfg_q.address    <= cfg_data_i;
        bsfb_pkg::CFG_CTRL_ZERO:  cfg_q.ctrl_zero  <= cfg_data_i;
        bsfb_pkg::CFG_CTRL_ONE:   cfg_q.ctrl_one   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o = queue_full;
  assign accept     = in_valid_i && !queue_full;

  bsfb_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_i),
    .cmd_o    (front_cmd)
  );

  bsfb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .wdata_i     (front_cmd),
    .pop_i       (pop),
    .rdata_o     (head_cmd),
    .not_empty_o (head_valid),
    .full_o      (queue_full)
  );

  bsfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (head_cmd),
    .cmd_valid_i (head_valid),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  `BSFB_ASSERT(a_close_is_last, out_valid_o && out_o.frame_end |-> out_o.run_last, "closing flag not last")
  `BSFB_ASSERT_ALWAYS(a_full_means_busy, in_stall_o |-> out_valid_o, "queue full while output idle")
  `BSFB_ASSERT(a_pop_needs_slot, pop |=> out_valid_o && out_o.run_last, "queue pop without final byte")

endmodule
